[hw/rtl/fpsch_pkg.sv]
// ----------------------------------------------------------------------------
// Frame pacing scheduler package
// Item types, operation and register codes, and fixed constants shared by
// the frame pacing scheduler modules.
// ----------------------------------------------------------------------------
package fpsch_pkg;

    // Timeline width in bits; times are in milliseconds
    localparam int TIME_BITS = 48;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Field widths
    localparam int OP_BITS       = 2;
    localparam int RENDER_BITS   = 32;
    localparam int COUNT_BITS    = 32;
    localparam int INTERVAL_BITS = 16;
    localparam int FPS_BITS      = 10;
    localparam int PERIOD_BITS   = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    // Interval divider: 1000 ms / fps, one quotient bit per cycle
    localparam int DIVIDEND      = 1000;
    localparam int DIV_STEPS     = FPS_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

    // Register reset values and the interval they give
    localparam int RESET_MIN_INTERVAL = 16;
    localparam int RESET_TARGET_FPS   = 30;
    localparam int RESET_TARGET_MS    = DIVIDEND / RESET_TARGET_FPS;
    localparam logic [INTERVAL_BITS-1:0] RESET_INTERVAL =
        INTERVAL_BITS'((RESET_TARGET_MS > RESET_MIN_INTERVAL) ?
                       RESET_TARGET_MS : RESET_MIN_INTERVAL);

    // Operation codes
    typedef enum logic [OP_BITS-1:0] {
        OP_BEGIN_FRAME = 2'd0,
        OP_END_FRAME   = 2'd1,
        OP_MARK_DIRTY  = 2'd2
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MIN_INTERVAL   = 2'd0,
        CFG_TARGET_FPS     = 2'd1,
        CFG_REFRESH_PERIOD = 2'd2
    } t_cfg_idx;

    // Input item
    typedef struct packed {
        logic [OP_BITS-1:0]     operation;
        logic [TIME_BITS-1:0]   now_ms;
        logic [RENDER_BITS-1:0] render_ms;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic                     render_now;
        logic [TIME_BITS-1:0]     next_due_ms;
        logic [COUNT_BITS-1:0]    skipped_count;
        logic [COUNT_BITS-1:0]    rendered_count;
        logic [COUNT_BITS-1:0]    overrun_count;
        logic [RENDER_BITS-1:0]   worst_render_ms;
        logic [RENDER_BITS-1:0]   last_render_ms;
        logic [TIME_BITS-1:0]     last_present_ms;
        logic [INTERVAL_BITS-1:0] interval_ms;
    } t_out_item;

    // Settings handed from the configuration block to the pacing core
    typedef struct packed {
        logic                     busy;
        logic [INTERVAL_BITS-1:0] interval;
        logic [PERIOD_BITS-1:0]   refresh_period;
    } t_cfg_state;

endpackage

[hw/rtl/fpsch_cfg.sv]
// ----------------------------------------------------------------------------
// Frame pacing scheduler configuration
// Holds the configuration registers and derives the frame interval
// max(1000 / fps, floor) with a bit-serial restoring divider after each write to a valid index.
// ----------------------------------------------------------------------------
module fpsch_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fpsch_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [fpsch_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output fpsch_pkg::t_cfg_state          o_cfg
);
    import fpsch_pkg::*;

    logic [INTERVAL_BITS-1:0] r_min_interval, n_min_interval;
    logic [FPS_BITS-1:0]      r_target_fps, n_target_fps;
    logic [PERIOD_BITS-1:0]   r_refresh_period, n_refresh_period;
    logic [INTERVAL_BITS-1:0] r_interval;

    logic                     r_busy;
    logic [DIV_CNT_BITS-1:0]  r_div_cnt;
    logic [FPS_BITS-1:0]      r_divisor;
    logic [FPS_BITS-1:0]      r_dvd;
    logic [FPS_BITS-1:0]      r_rem;
    logic [FPS_BITS-1:0]      r_quo;

    logic                     cfg_write;
    logic                     idx_valid;
    logic [FPS_BITS:0]        trial;
    logic [FPS_BITS-1:0]      trial_diff;
    logic                     fits;
    logic [FPS_BITS-1:0]      n_quo;
    logic [INTERVAL_BITS-1:0] floor_eff;
    logic [INTERVAL_BITS-1:0] quo_ext;
    logic                     div_last;

    assign o_cfg_ready = !r_busy;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // Register write decode
    always_comb begin
        n_min_interval   = r_min_interval;
        n_target_fps     = r_target_fps;
        n_refresh_period = r_refresh_period;
        idx_valid        = 1'b1;
        unique case (i_cfg_index)
            CFG_MIN_INTERVAL:   n_min_interval   = i_cfg_data[INTERVAL_BITS-1:0];
            CFG_TARGET_FPS:     n_target_fps     = i_cfg_data[FPS_BITS-1:0];
            CFG_REFRESH_PERIOD: n_refresh_period = i_cfg_data[PERIOD_BITS-1:0];
            default:            idx_valid        = 1'b0;
        endcase
    end

    // One restoring division step; a fitting difference is below the divisor
    always_comb begin
        trial      = {r_rem, r_dvd[FPS_BITS-1]};
        trial_diff = trial[FPS_BITS-1:0] - r_divisor;
        fits       = (trial >= {1'b0, r_divisor});
        n_quo      = {r_quo[FPS_BITS-2:0], fits};
        div_last   = (r_div_cnt == '0);
        floor_eff  = (r_min_interval == '0) ? INTERVAL_BITS'(1) : r_min_interval;
        quo_ext    = {{(INTERVAL_BITS-FPS_BITS){1'b0}}, n_quo};
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval   <= INTERVAL_BITS'(RESET_MIN_INTERVAL);
            r_target_fps     <= FPS_BITS'(RESET_TARGET_FPS);
            r_refresh_period <= '0;
        end else if (cfg_write) begin
            r_min_interval   <= n_min_interval;
            r_target_fps     <= n_target_fps;
            r_refresh_period <= n_refresh_period;
        end
    end

    // Divider control and interval result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_div_cnt  <= '0;
            r_interval <= RESET_INTERVAL;
        end else if (cfg_write && idx_valid) begin
            r_busy    <= 1'b1;
            r_div_cnt <= DIV_CNT_BITS'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_div_cnt <= r_div_cnt - 1'b1;
            if (div_last) begin
                r_busy     <= 1'b0;
                r_interval <= (quo_ext > floor_eff) ? quo_ext : floor_eff;
            end
        end
    end

    // Divider datapath
    always_ff @(posedge i_clk) begin
        if (cfg_write && idx_valid) begin
            r_divisor <= (n_target_fps == '0) ? FPS_BITS'(1) : n_target_fps;
            r_dvd     <= FPS_BITS'(DIVIDEND);
            r_rem     <= '0;
            r_quo     <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? trial_diff : trial[FPS_BITS-1:0];
            r_dvd <= {r_dvd[FPS_BITS-2:0], 1'b0};
            r_quo <= n_quo;
        end
    end

    assign o_cfg.busy           = r_busy;
    assign o_cfg.interval       = r_interval;
    assign o_cfg.refresh_period = r_refresh_period;

endmodule

[hw/rtl/fpsch_core.sv]
// ----------------------------------------------------------------------------
// Frame pacing scheduler core
// Pacing state and the single-pass update for begin-frame, end-frame and
// mark-dirty operations; produces the result item for each step.
// ----------------------------------------------------------------------------
module fpsch_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  fpsch_pkg::t_in_item   i_item,
    input  fpsch_pkg::t_cfg_state i_cfg,
    output fpsch_pkg::t_out_item  o_result
);
    import fpsch_pkg::*;

    logic [TIME_BITS-1:0]   r_last_eval, n_last_eval;
    logic [TIME_BITS-1:0]   r_last_present, n_last_present;
    logic                   r_has_rendered, n_has_rendered;
    logic                   r_dirty, n_dirty;
    logic [COUNT_BITS-1:0]  r_skip_cnt, n_skip_cnt;
    logic [COUNT_BITS-1:0]  r_render_cnt, n_render_cnt;
    logic [COUNT_BITS-1:0]  r_overrun_cnt, n_overrun_cnt;
    logic [RENDER_BITS-1:0] r_worst_render, n_worst_render;
    logic [RENDER_BITS-1:0] r_last_render, n_last_render;
    logic [TIME_BITS-1:0]   r_present_stat, n_present_stat;

    logic [TIME_BITS-1:0]   now;
    logic [TIME_BITS-1:0]   interval_ext;
    logic [TIME_BITS-1:0]   period_ext;
    logic [TIME_BITS-1:0]   base_eval;
    logic [TIME_BITS-1:0]   base_present;
    logic [TIME_BITS-1:0]   elapsed;
    logic [TIME_BITS-1:0]   age;
    logic                   back;
    logic                   due;
    logic                   refresh;
    logic                   skip_frame;
    logic                   render;
    logic                   eval_moved;
    logic [TIME_BITS:0]     sum_old;
    logic [TIME_BITS:0]     sum_now;
    logic [TIME_BITS-1:0]   due_old;
    logic [TIME_BITS-1:0]   due_now;
    logic [TIME_BITS-1:0]   due_sel;
    logic [TIME_BITS-1:0]   next_due;

    assign now          = i_item.now_ms;
    assign interval_ext = {{(TIME_BITS-INTERVAL_BITS){1'b0}}, i_cfg.interval};
    assign period_ext   = {{(TIME_BITS-PERIOD_BITS){1'b0}}, i_cfg.refresh_period};

    // Begin-frame decision: re-baseline on a backward step, then due and refresh
    always_comb begin
        back         = (now < r_last_eval);
        base_eval    = back ? now : r_last_eval;
        base_present = back ? now : r_last_present;
        elapsed      = now - base_eval;
        age          = now - base_present;
        due          = !r_has_rendered || back || (elapsed >= interval_ext);
        refresh      = (i_cfg.refresh_period != '0) && (age >= period_ext);
        skip_frame   = due && !r_dirty && !refresh;
    end

    // Next state per operation
    always_comb begin
        n_last_eval    = r_last_eval;
        n_last_present = r_last_present;
        n_has_rendered = r_has_rendered;
        n_dirty        = r_dirty;
        n_skip_cnt     = r_skip_cnt;
        n_render_cnt   = r_render_cnt;
        n_overrun_cnt  = r_overrun_cnt;
        n_worst_render = r_worst_render;
        n_last_render  = r_last_render;
        n_present_stat = r_present_stat;
        render         = 1'b0;
        eval_moved     = 1'b0;
        unique case (i_item.operation)
            OP_BEGIN_FRAME: begin
                n_last_present = base_present;
                if (due) begin
                    n_last_eval = now;
                    eval_moved  = 1'b1;
                end
                if (skip_frame) begin
                    n_skip_cnt = r_skip_cnt + 1'b1;
                end
                render = due && !skip_frame;
            end
            OP_END_FRAME: begin
                n_dirty        = 1'b0;
                n_has_rendered = 1'b1;
                n_last_present = now;
                n_render_cnt   = r_render_cnt + 1'b1;
                n_last_render  = i_item.render_ms;
                n_present_stat = now;
                if (i_item.render_ms > r_worst_render) begin
                    n_worst_render = i_item.render_ms;
                end
                if ({{(TIME_BITS-RENDER_BITS){1'b0}}, i_item.render_ms} > interval_ext) begin
                    n_overrun_cnt = r_overrun_cnt + 1'b1;
                end
            end
            OP_MARK_DIRTY: begin
                n_dirty = 1'b1;
            end
            default: begin
                n_dirty = r_dirty;
            end
        endcase
    end

    // Next due time, saturating at the top of the timeline
    always_comb begin
        sum_old  = {1'b0, r_last_eval} + {1'b0, interval_ext};
        sum_now  = {1'b0, now} + {1'b0, interval_ext};
        due_old  = sum_old[TIME_BITS] ? TIME_MAX : sum_old[TIME_BITS-1:0];
        due_now  = sum_now[TIME_BITS] ? TIME_MAX : sum_now[TIME_BITS-1:0];
        due_sel  = eval_moved ? due_now : due_old;
        if (!n_has_rendered) begin
            next_due = now;
        end else begin
            next_due = (due_sel > now) ? due_sel : now;
        end
    end

    // Pacing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_eval    <= '0;
            r_last_present <= '0;
            r_has_rendered <= 1'b0;
            r_dirty        <= 1'b1;
            r_skip_cnt     <= '0;
            r_render_cnt   <= '0;
            r_overrun_cnt  <= '0;
            r_worst_render <= '0;
            r_last_render  <= '0;
            r_present_stat <= '0;
        end else if (i_step) begin
            r_last_eval    <= n_last_eval;
            r_last_present <= n_last_present;
            r_has_rendered <= n_has_rendered;
            r_dirty        <= n_dirty;
            r_skip_cnt     <= n_skip_cnt;
            r_render_cnt   <= n_render_cnt;
            r_overrun_cnt  <= n_overrun_cnt;
            r_worst_render <= n_worst_render;
            r_last_render  <= n_last_render;
            r_present_stat <= n_present_stat;
        end
    end

    // Result reflects the state after this operation
    always_comb begin
        o_result.render_now      = render;
        o_result.next_due_ms     = next_due;
        o_result.skipped_count   = n_skip_cnt;
        o_result.rendered_count  = n_render_cnt;
        o_result.overrun_count   = n_overrun_cnt;
        o_result.worst_render_ms = n_worst_render;
        o_result.last_render_ms  = n_last_render;
        o_result.last_present_ms = n_present_stat;
        o_result.interval_ms     = i_cfg.interval;
    end

endmodule

[hw/rtl/frame_pacing_scheduler.sv]
// ----------------------------------------------------------------------------
// Frame pacing scheduler
// Decides when display frames render and keeps frame statistics.
// ----------------------------------------------------------------------------
// One operation is accepted per clock while the input is not stalled. The item
// waits in the input register, then the pacing update lands in the result
// register. The result register holds under output stall while a new item is
// still taken when that register drains in the same cycle. A write to any
// valid configuration register recomputes the frame interval with a bit-serial
// divider; while the divider runs the configuration port is not ready and
// input transfers are stalled.
// Writes to an index past the register list are taken and ignored.
module frame_pacing_scheduler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fpsch_pkg::t_in_item                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fpsch_pkg::t_out_item                o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fpsch_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [fpsch_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import fpsch_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;

    t_cfg_state cfg;
    t_out_item  result;
    logic       out_load;
    logic       in_take;
    logic       step;

    // Configuration registers and interval divider
    fpsch_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Pacing state and update
    fpsch_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Pipeline flow control
    assign out_load   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_load;
    assign o_in_stall = cfg.busy || (r_in_valid && !out_load);
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (out_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[sim/fpsch_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame pacing scheduler checker
// Watches the configuration, input and result channels of the scheduler.
// It keeps its own copy of the pacing state and computes the result of each
// input transfer, then compares each result transfer field by field with the
// oldest pending prediction.
// ----------------------------------------------------------------------------
module fpsch_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  fpsch_pkg::t_in_item                 i_in_data,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  fpsch_pkg::t_out_item                i_out_data,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [fpsch_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [fpsch_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import fpsch_pkg::*;

    // Register copies
    logic [INTERVAL_BITS-1:0] floor_ms;
    logic [FPS_BITS-1:0]      fps;
    logic [PERIOD_BITS-1:0]   refresh_ms;

    // Pacing state
    logic [INTERVAL_BITS-1:0] interval;
    logic [TIME_BITS-1:0]     eval_time;
    logic [TIME_BITS-1:0]     present_time;
    logic [TIME_BITS-1:0]     present_stat;
    logic                     rendered_any;
    logic                     content_dirty;
    logic [COUNT_BITS-1:0]    skips;
    logic [COUNT_BITS-1:0]    renders;
    logic [COUNT_BITS-1:0]    overruns;
    logic [RENDER_BITS-1:0]   worst_ms;
    logic [RENDER_BITS-1:0]   last_ms;

    t_out_item expected_results[$];
    int        fails = 0;

    // max(1000 / fps, floor), zero fps and zero floor both act as one
    function automatic logic [INTERVAL_BITS-1:0] pacing_interval(
        input logic [INTERVAL_BITS-1:0] flo,
        input logic [FPS_BITS-1:0]      rate
    );
        int f;
        int r;
        int per_frame;
        f = (flo == '0) ? 1 : int'(flo);
        r = (rate == '0) ? 1 : int'(rate);
        per_frame = DIVIDEND / r;
        return INTERVAL_BITS'((per_frame > f) ? per_frame : f);
    endfunction

    // Applies one operation to the pacing state and builds its result
    function automatic t_out_item pace_step(input t_in_item it);
        t_out_item            r;
        logic [TIME_BITS-1:0] now;
        logic [TIME_BITS-1:0] age;
        logic [TIME_BITS-1:0] due_at;
        logic                 back;
        logic                 due;
        logic                 refresh;
        r   = '0;
        now = it.now_ms;
        case (it.operation)
            OP_BEGIN_FRAME: begin
                // backward clock step re-baselines and forces a due frame
                back = now < eval_time;
                if (back) begin
                    eval_time    = now;
                    present_time = now;
                end
                due = !rendered_any || back || ((now - eval_time) >= TIME_BITS'(interval));
                if (due) begin
                    eval_time = now;
                    age       = now - present_time;
                    refresh   = (refresh_ms != '0) && (age >= TIME_BITS'(refresh_ms));
                    if (!content_dirty && !refresh) begin
                        skips = skips + 1'b1;
                    end else begin
                        r.render_now = 1'b1;
                    end
                end
            end
            OP_END_FRAME: begin
                content_dirty = 1'b0;
                rendered_any  = 1'b1;
                present_time  = now;
                present_stat  = now;
                renders       = renders + 1'b1;
                last_ms       = it.render_ms;
                if (it.render_ms > worst_ms) begin
                    worst_ms = it.render_ms;
                end
                if (it.render_ms > RENDER_BITS'(interval)) begin
                    overruns = overruns + 1'b1;
                end
            end
            OP_MARK_DIRTY: begin
                content_dirty = 1'b1;
            end
            default: ;
        endcase

        // next due time saturates at the top of the timeline, never before now
        if (!rendered_any) begin
            due_at = now;
        end else if (eval_time > TIME_MAX - TIME_BITS'(interval)) begin
            due_at = TIME_MAX;
        end else begin
            due_at = eval_time + TIME_BITS'(interval);
        end
        if (due_at < now) begin
            due_at = now;
        end

        r.next_due_ms     = due_at;
        r.skipped_count   = skips;
        r.rendered_count  = renders;
        r.overrun_count   = overruns;
        r.worst_render_ms = worst_ms;
        r.last_render_ms  = last_ms;
        r.last_present_ms = present_stat;
        r.interval_ms     = interval;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    // Channel monitor: config writes, result compare, then new predictions
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            floor_ms      = INTERVAL_BITS'(RESET_MIN_INTERVAL);
            fps           = FPS_BITS'(RESET_TARGET_FPS);
            refresh_ms    = '0;
            interval      = pacing_interval(floor_ms, fps);
            eval_time     = '0;
            present_time  = '0;
            present_stat  = '0;
            rendered_any  = 1'b0;
            content_dirty = 1'b1;
            skips         = '0;
            renders       = '0;
            overruns      = '0;
            worst_ms      = '0;
            last_ms       = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_INTERVAL:   floor_ms   = i_cfg_data[INTERVAL_BITS-1:0];
                    CFG_TARGET_FPS:     fps        = i_cfg_data[FPS_BITS-1:0];
                    CFG_REFRESH_PERIOD: refresh_ms = i_cfg_data[PERIOD_BITS-1:0];
                    default: ;
                endcase
                interval = pacing_interval(floor_ms, fps);
            end

            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no result expected");
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("render_now", want.render_now, i_out_data.render_now);
                    check_field("next_due_ms", want.next_due_ms, i_out_data.next_due_ms);
                    check_field("skipped_count", want.skipped_count, i_out_data.skipped_count);
                    check_field("rendered_count", want.rendered_count,
                                i_out_data.rendered_count);
                    check_field("overrun_count", want.overrun_count, i_out_data.overrun_count);
                    check_field("worst_render_ms", want.worst_render_ms,
                                i_out_data.worst_render_ms);
                    check_field("last_render_ms", want.last_render_ms,
                                i_out_data.last_render_ms);
                    check_field("last_present_ms", want.last_present_ms,
                                i_out_data.last_present_ms);
                    check_field("interval_ms", want.interval_ms, i_out_data.interval_ms);
                end
            end

            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(pace_step(i_in_data));
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fails;
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame pacing scheduler testbench
// Drives a directed frame sequence and then randomized frame traffic through
// several register settings, with random gaps and stalls on both channels and
// one long result hold-off. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import fpsch_pkg::*;

    localparam int RESET_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 700;
    localparam int PHASES         = 7;

    // Codes outside the defined lists, still legal on the wires
    localparam logic [OP_BITS-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    t_in_item                 in_data   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    t_out_item                out_data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    int                       fail_count;
    int                       pending;

    // Traffic shaping controls
    logic                     tx_quiet  = 1'b0;
    logic                     rx_quiet  = 1'b0;
    logic                     hold_req  = 1'b0;
    logic [TIME_BITS-1:0]     t_ms      = '0;
    int                       stuck     = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    frame_pacing_scheduler u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fpsch_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly no gap, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TIME_BITS-1:0] rand_time();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [RENDER_BITS-1:0] pick_render();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(0, 60);
        if (r < 9) return $urandom_range(0, 70000);
        return $urandom;
    endfunction

    // One input transfer, after an optional idle gap
    task automatic send_item(
        input logic [OP_BITS-1:0]     op,
        input logic [TIME_BITS-1:0]   now,
        input logic [RENDER_BITS-1:0] rms
    );
        int       gap;
        t_in_item it;
        gap          = tx_quiet ? 0 : idle_len();
        it.operation = op;
        it.now_ms    = now;
        it.render_ms = rms;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Register write once every result is back
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Frame traffic: mostly dirty/begin/end sequences on a moving timeline
    task automatic random_phase(input int count);
        int                     n;
        int                     r;
        int                     s;
        logic [RENDER_BITS-1:0] rms;
        n = 0;
        while (n < count) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                if ($urandom_range(0, 1) == 1) begin
                    send_item(OP_MARK_DIRTY, t_ms, $urandom);
                    n++;
                end
                send_item(OP_BEGIN_FRAME, t_ms, $urandom);
                n++;
                if ($urandom_range(0, 9) < 7) begin
                    rms = pick_render();
                    send_item(OP_END_FRAME, t_ms + TIME_BITS'($urandom_range(0, 40)), rms);
                    n++;
                end
                s = $urandom_range(0, 9);
                if (s < 3) begin
                    t_ms = t_ms + TIME_BITS'($urandom_range(0, 5));
                end else if (s < 8) begin
                    t_ms = t_ms + TIME_BITS'($urandom_range(1, 80));
                end else if (s < 9) begin
                    t_ms = t_ms + TIME_BITS'($urandom_range(1, 3000));
                end else begin
                    t_ms = t_ms + TIME_BITS'($urandom_range(60000, 70000));
                end
            end else if (r < 88) begin
                // clock steps backward
                t_ms = t_ms - TIME_BITS'($urandom_range(1, 500));
            end else if (r < 92) begin
                t_ms = TIME_MAX - TIME_BITS'($urandom_range(0, 200));
            end else begin
                send_item(OP_BITS'($urandom_range(0, 3)), rand_time(), $urandom);
                n++;
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : rx_side
        logic held;
        int   n;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                n = rx_quiet ? 0 : idle_len();
                if (n > 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
        end
        if (stuck >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        int                       p;
        logic [CFG_DATA_BITS-1:0] v;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings give a 33 ms interval, refresh off
        send_item(OP_BEGIN_FRAME, 0, 0);               // first frame is always due
        send_item(OP_END_FRAME, 5, 40);                // overrun
        send_item(OP_BEGIN_FRAME, 10, 0);              // not yet due
        send_item(OP_BEGIN_FRAME, 40, 0);              // due but clean: skipped
        send_item(OP_MARK_DIRTY, 41, 0);
        send_item(OP_BEGIN_FRAME, 80, 0);
        send_item(OP_END_FRAME, 85, 32'hFFFF_FFFF);    // worst render at the top
        send_item(OP_UNUSED, 90, 32'hFFFF_FFFF);       // unused code changes nothing
        send_item(OP_BEGIN_FRAME, 20, 0);              // backward step
        send_item(OP_END_FRAME, 30, 0);
        send_item(OP_BEGIN_FRAME, TIME_MAX - 5, 0);    // next due saturates
        send_item(OP_MARK_DIRTY, TIME_MAX, 0);
        send_item(OP_BEGIN_FRAME, TIME_MAX, 0);
        send_item(OP_END_FRAME, TIME_MAX, 33);         // equal to interval, no overrun
        send_item(OP_BEGIN_FRAME, 0, 0);

        // zero floor and zero fps, refresh every ms
        write_reg(CFG_MIN_INTERVAL, 32'hFFFF_0000);
        write_reg(CFG_TARGET_FPS, 32'hFFFF_FC00);
        write_reg(CFG_REFRESH_PERIOD, 1);
        send_item(OP_END_FRAME, 5000, 1001);           // present time ahead of later frames
        send_item(OP_BEGIN_FRAME, 1000, 0);
        send_item(OP_BEGIN_FRAME, 2000, 0);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        write_reg(CFG_REFRESH_PERIOD, 32'hFFFF_FFFF);
        send_item(OP_BEGIN_FRAME, 3000, 0);            // wrapped refresh age
        send_item(OP_BEGIN_FRAME, 3500, 0);
        send_item(OP_UNUSED, TIME_MAX, 32'hFFFF_FFFF);
        t_ms = 4000;

        // Random phases, each under its own register setting
        for (p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                write_reg(CFG_MIN_INTERVAL, 1);
                write_reg(CFG_TARGET_FPS, 1000);
            end else if (p == PHASES - 1) begin
                v = $urandom;
                v[INTERVAL_BITS-1:0] = '1;
                write_reg(CFG_MIN_INTERVAL, v);
                write_reg(CFG_TARGET_FPS, 1);
            end else begin
                v = $urandom;
                case ($urandom_range(0, 4))
                    0: v[INTERVAL_BITS-1:0] = '0;
                    1: v[INTERVAL_BITS-1:0] = '1;
                    2, 3: v[INTERVAL_BITS-1:0] = INTERVAL_BITS'($urandom_range(2, 50));
                    default: ;
                endcase
                write_reg(CFG_MIN_INTERVAL, v);
                v = $urandom;
                case ($urandom_range(0, 4))
                    0: v[FPS_BITS-1:0] = '0;
                    1: v[FPS_BITS-1:0] = FPS_BITS'(1000);
                    2, 3: v[FPS_BITS-1:0] = FPS_BITS'($urandom_range(2, 120));
                    default: ;
                endcase
                write_reg(CFG_TARGET_FPS, v);
            end
            case ($urandom_range(0, 5))
                0, 1: v = '0;
                2: v = 1;
                3: v = $urandom_range(20, 300);
                4: v = '1;
                default: v = $urandom;
            endcase
            write_reg(CFG_REFRESH_PERIOD, v);
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_UNUSED, $urandom);
            end
            tx_quiet <= (p == 2) || (p == 4);
            rx_quiet <= (p == 2);
            hold_req <= (p == 4);
            random_phase(RANDOM_ITEMS / PHASES);
        end

        // Drain and verdict
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
